FILE: rtl/core/battery_charge_state_detector_top_defines.svh
// ----------------------------------------------------------------------------
// Battery charge state detector: assertion macros
// Shared macros for the concurrent checks of the detector top level.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_STATE_DETECTOR_TOP_DEFINES_SVH
`define BATTERY_CHARGE_STATE_DETECTOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define BCSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define BCSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BCSD_ASSERT_IMP(label, ante, cons, msg)
`define BCSD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/bcsd_pkg.sv
// ----------------------------------------------------------------------------
// Battery charge state detector package
// Shared state codes, register indexes and arithmetic widths.
// ----------------------------------------------------------------------------
package bcsd_pkg;

  typedef enum logic [1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_CHARGING = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTCHG   = 2'd3
  } charge_code_t;

  localparam logic [2:0] REG_FULL_MV      = 3'd0;
  localparam logic [2:0] REG_FULL_HARD_MV = 3'd1;
  localparam logic [2:0] REG_NOTCHG_MV    = 3'd2;
  localparam logic [2:0] REG_SLOPE_ON     = 3'd3;
  localparam logic [2:0] REG_SLOPE_OFF    = 3'd4;
  localparam logic [2:0] REG_SLOPE_FLAT   = 3'd5;
  localparam logic [2:0] REG_HOLD_FULL    = 3'd6;
  localparam logic [2:0] REG_HOLD_SHORT   = 3'd7;

  // Divider: dividend is |dv| * 1e6 * 2^16, divisor is the elapsed time.
  localparam int NUM_W  = 49;
  localparam int DEN_W  = 16;
  localparam int DCNT_W = 6;

  localparam logic [32:0] UV_PER_MV  = 33'd1000000;
  localparam logic [47:0] SLOPE_LIM  = 48'h7FFF_FFFF_FFFF;
  localparam logic [31:0] U32_MAX    = 32'hFFFF_FFFF;

endpackage

FILE: rtl/core/battery_charge_state_detector_top.sv
// ----------------------------------------------------------------------------
// Battery charge state detector, top level
// Filters voltage and slope and reports a debounced charge state.
// ----------------------------------------------------------------------------
// Usage: each input beat on the s_ channel carries a voltage sample in mV and
// the milliseconds since the previous sample. Each accepted beat produces
// exactly one result beat on the m_ channel with the reported charge state,
// the target chosen for this sample, the filtered voltage, the filtered slope
// in uV/s and the time the target has persisted.
// A sample passes PREP, DIV, INST, SMUL and DECIDE, then DONE offers its
// result on m_tvalid. The slope divider dominates: it produces one quotient
// bit per cycle over 49 bits, followed by the serial slope filter multiply.
// The voltage filter multiply runs in the shadow of the divider. One sample
// is processed at a time. If the receiver stalls, the finished result waits
// in the output register; the next sample may still be accepted and
// processed, and it waits at the end of processing until the output register
// frees up. Reset (synchronous, active high) restores all thresholds to their
// defaults and clears the filters, timers and state; the first sample after
// reset seeds the voltage filter. Thresholds are written over the APB port;
// the user must write them only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module battery_charge_state_detector_top #(
  parameter int ALPHA_VOLT_Q16        = 6554,
  parameter int ALPHA_SLOPE_Q16       = 5243,
  parameter int RELAX_AFTER_DETACH_MS = 90000
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream: [12:0] voltage_mv, [28:13] elapsed_ms, rest zero.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // Output stream: [1:0] charge_state, [3:2] target_state, [16:4] filtered_mv,
  // [48:17] slope_uv_per_s, [80:49] time_in_target_ms, rest zero.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcsd_pkg::*;

  localparam logic [15:0] AV      = 16'(ALPHA_VOLT_Q16);
  localparam logic [15:0] AS      = 16'(ALPHA_SLOPE_Q16);
  localparam logic [31:0] RELAX_T = 32'(RELAX_AFTER_DETACH_MS);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV, S_INST, S_SMUL, S_DECIDE, S_DONE
  } state_t;

  state_t state;

  // Threshold registers.
  logic [12:0] full_mv, full_hard_mv, notchg_mv;
  logic [16:0] slope_on, slope_off, slope_flat;
  logic [21:0] hold_full, hold_short;

  // Detector state.
  logic [28:0]        voltage_ema;
  logic signed [47:0] slope_ema;
  logic [12:0]        previous_mv;
  logic               seen_first;
  charge_code_t       last_target;
  charge_code_t       stable_state;
  logic [31:0]        target_age;
  logic [31:0]        since_detach;

  // Per-sample working registers.
  logic [15:0]        dt;
  logic [15:0]        divisor;
  logic [12:0]        dmag;
  logic               neg;
  logic signed [29:0] vdiff;
  logic signed [47:0] inst;
  logic [87:0]        result;

  // Sample fields and seeded values at acceptance.
  logic [12:0]        in_v;
  logic [15:0]        in_dt;
  logic [28:0]        vema_eff;
  logic [12:0]        prev_eff;
  logic               in_acc;

  assign in_v     = s_tdata[12:0];
  assign in_dt    = s_tdata[28:13];
  assign vema_eff = seen_first ? voltage_ema : {in_v, 16'b0};
  assign prev_eff = seen_first ? previous_mv : in_v;
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // Serial units.
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      quot;
  logic [32:0]           dprod;
  logic                  vm_start, vm_done, sm_start, sm_done;
  logic signed [45:0]    vprod;
  logic signed [64:0]    sprod;
  logic signed [48:0]    sdiff;

  assign dprod     = 33'(dmag) * UV_PER_MV;
  assign div_start = (state == S_PREP);
  assign vm_start  = (state == S_PREP);
  assign sm_start  = (state == S_INST);
  assign sdiff     = 49'(inst) - 49'(slope_ema);

  bcsd_sdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer ({dprod, 16'b0}),
    .denom (divisor),
    .done  (div_done),
    .quot  (quot)
  );

  bcsd_smul #(.W(30)) u_vmul (
    .clk   (clk),
    .rst   (rst),
    .start (vm_start),
    .x     (vdiff),
    .coef  (AV),
    .done  (vm_done),
    .prod  (vprod)
  );

  bcsd_smul #(.W(49)) u_smul (
    .clk   (clk),
    .rst   (rst),
    .start (sm_start),
    .x     (sdiff),
    .coef  (AS),
    .done  (sm_done),
    .prod  (sprod)
  );

  // Saturated, signed instantaneous slope from the quotient.
  logic [47:0] qsat;
  assign qsat = (quot[NUM_W-1:NUM_W-2] != 2'b00) ? SLOPE_LIM : quot[47:0];

  // Decision logic on the freshly updated filters.
  logic [47:0] mag;
  logic [33:0] flat1, flat2;
  logic        vge_hard, vge_full, vle_notchg, s_ge_on, s_ge_off, s_le_zero;
  charge_code_t target, stable_next;
  logic        promote;
  logic [32:0] age_sum, det_sum;
  logic [31:0] age_next, since_next;
  charge_code_t charge_out;
  logic [31:0] slope_int;

  always_comb begin
    mag        = slope_ema[47] ? 48'(-slope_ema) : 48'(slope_ema);
    flat1      = {1'b0, slope_flat, 16'b0};
    flat2      = {slope_flat, 17'b0};
    vge_hard   = voltage_ema >= {full_hard_mv, 16'b0};
    vge_full   = voltage_ema >= {full_mv, 16'b0};
    vle_notchg = voltage_ema <= {notchg_mv, 16'b0};
    s_ge_on    = slope_ema >= $signed({15'b0, slope_on, 16'b0});
    s_ge_off   = slope_ema >= $signed({15'b0, slope_off, 16'b0});
    s_le_zero  = slope_ema[47] || (slope_ema == '0);

    if (vge_hard && (48'(flat2) > mag)) begin
      target = ST_FULL;
    end else if (vge_full && (48'(flat1) > mag)) begin
      target = ST_FULL;
    end else if (s_ge_on) begin
      target = ST_CHARGING;
    end else if (s_le_zero || vle_notchg) begin
      target = ST_NOTCHG;
    end else if (stable_state == ST_UNKNOWN) begin
      target = ST_NOTCHG;
    end else begin
      target = stable_state;
    end

    case (target)
      ST_FULL:     promote = (target_age >= 32'(hold_full)) || vge_hard;
      ST_CHARGING: promote = s_ge_off && (target_age >= 32'(hold_short));
      ST_NOTCHG:   promote = (target_age >= 32'(hold_short)) &&
                             ((since_detach >= RELAX_T) || (stable_state != ST_CHARGING));
      default:     promote = 1'b1;
    endcase

    age_sum = {1'b0, target_age} + 33'(dt);
    if (target != last_target) begin
      age_next = '0;
    end else begin
      age_next = age_sum[32] ? U32_MAX : age_sum[31:0];
    end

    det_sum     = {1'b0, since_detach} + 33'(dt);
    stable_next = stable_state;
    since_next  = since_detach;
    if (promote && (target != stable_state)) begin
      if (stable_state == ST_CHARGING) begin
        since_next = '0;
      end
      stable_next = target;
    end else if (stable_state != ST_CHARGING) begin
      since_next = det_sum[32] ? U32_MAX : det_sum[31:0];
    end

    charge_out = (stable_next == ST_UNKNOWN) ? target : stable_next;
    slope_int  = slope_ema[47:16];
  end

  function automatic logic signed [48:0] sdiff_base(input logic signed [47:0] e,
                                                    input logic signed [64:0] p);
    logic signed [64:0] sh;
    sh = p >>> 16;
    return 49'(e) + sh[48:0];
  endfunction

  // Main sequencer: owns the state and the registered m_tvalid output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      voltage_ema  <= '0;
      slope_ema    <= '0;
      previous_mv  <= '0;
      seen_first   <= 1'b0;
      last_target  <= ST_UNKNOWN;
      stable_state <= ST_UNKNOWN;
      target_age   <= '0;
      since_detach <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // A finished result is offered once the output register is free;
      // otherwise an accepted beat empties it.
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // The voltage multiply always completes while the divider runs.
      if (vm_done) begin
        voltage_ema <= 29'(30'(voltage_ema) + 30'(vprod >>> 16));
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            voltage_ema <= vema_eff;
            previous_mv <= in_v;
            seen_first  <= 1'b1;
            state       <= S_PREP;
          end
        end
        S_PREP: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_INST;
          end
        end
        S_INST: state <= S_SMUL;
        S_SMUL: begin
          if (sm_done) begin
            slope_ema <= 48'(sdiff_base(slope_ema, sprod));
            state     <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          last_target  <= target;
          stable_state <= stable_next;
          target_age   <= age_next;
          since_detach <= since_next;
          state        <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Per-sample payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt      <= in_dt;
      divisor <= (in_dt == '0) ? 16'd1 : in_dt;
      neg     <= in_v < prev_eff;
      dmag    <= (in_v < prev_eff) ? (prev_eff - in_v) : (in_v - prev_eff);
      vdiff   <= $signed({1'b0, in_v, 16'b0}) - $signed({1'b0, vema_eff});
    end
    if (state == S_DIV && div_done) begin
      inst <= neg ? -$signed(qsat) : $signed(qsat);
    end
    if (state == S_DECIDE) begin
      result <= {7'b0, age_next, slope_int, voltage_ema[28:16], 2'(target), 2'(charge_out)};
    end
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= result;
    end
  end

  // Configuration registers.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_mv      <= 13'd4180;
      full_hard_mv <= 13'd4220;
      notchg_mv    <= 13'd4120;
      slope_on     <= 17'd1000;
      slope_off    <= 17'd300;
      slope_flat   <= 17'd100;
      hold_full    <= 22'd60000;
      hold_short   <= 22'd15000;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_FULL_MV:      full_mv      <= pwdata[12:0];
        REG_FULL_HARD_MV: full_hard_mv <= pwdata[12:0];
        REG_NOTCHG_MV:    notchg_mv    <= pwdata[12:0];
        REG_SLOPE_ON:     slope_on     <= pwdata[16:0];
        REG_SLOPE_OFF:    slope_off    <= pwdata[16:0];
        REG_SLOPE_FLAT:   slope_flat   <= pwdata[16:0];
        REG_HOLD_FULL:    hold_full    <= pwdata[21:0];
        REG_HOLD_SHORT:   hold_short   <= pwdata[21:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FULL_MV:      prdata = 32'(full_mv);
      REG_FULL_HARD_MV: prdata = 32'(full_hard_mv);
      REG_NOTCHG_MV:    prdata = 32'(notchg_mv);
      REG_SLOPE_ON:     prdata = 32'(slope_on);
      REG_SLOPE_OFF:    prdata = 32'(slope_off);
      REG_SLOPE_FLAT:   prdata = 32'(slope_flat);
      REG_HOLD_FULL:    prdata = 32'(hold_full);
      REG_HOLD_SHORT:   prdata = 32'(hold_short);
      default:          prdata = '0;
    endcase
  end

  // Checks.
`include "battery_charge_state_detector_top_defines.svh"
  `BCSD_ASSERT_IMP(a_div_in_div, div_done, state == S_DIV, "divider finished outside DIV")
  `BCSD_ASSERT_IMP(a_vmul_in_div, vm_done, state == S_DIV, "voltage multiply late")
  `BCSD_ASSERT_NXT(a_busy_after_accept, in_acc, !s_tready, "accepted twice")
  `BCSD_ASSERT_IMP(a_target_known, m_tvalid, m_tdata[3:2] != 2'(ST_UNKNOWN), "unknown target")

endmodule

FILE: rtl/core/bcsd_sdiv.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module bcsd_sdiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bcsd_pkg::NUM_W-1:0] numer,
  input  logic [bcsd_pkg::DEN_W-1:0] denom,
  output logic                       done,
  output logic [bcsd_pkg::NUM_W-1:0] quot
);
  import bcsd_pkg::*;

  logic [NUM_W-1:0]  nsh;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [DCNT_W-1:0] cnt;
  logic              run;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, nsh[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DCNT_W'(NUM_W - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= numer;
      den  <= denom;
      rem  <= '0;
      quot <= '0;
    end else if (run) begin
      nsh  <= {nsh[NUM_W-2:0], 1'b0};
      quot <= {quot[NUM_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/core/bcsd_smul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed operand times a 16-bit unsigned coefficient, one coefficient bit
// per cycle, MSB first.
// ----------------------------------------------------------------------------
module bcsd_smul #(
  parameter int W = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] x,
  input  logic [15:0]         coef,
  output logic                done,
  output logic signed [W+15:0] prod
);
  import bcsd_pkg::*;

  logic signed [W-1:0] xr;
  logic [15:0]         csh;
  logic [3:0]          cnt;
  logic                run;
  logic signed [W+15:0] addend;

  assign addend = csh[15] ? {{16{xr[W-1]}}, xr} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      csh  <= coef;
      prod <= '0;
    end else if (run) begin
      csh  <= {csh[14:0], 1'b0};
      prod <= (prod <<< 1) + addend;
    end
  end

endmodule
